FILE: src/aeg_pkg.sv
// Shared types and codes for the ADSR envelope gain block.
package aeg_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] MODE_SAMPLE   = 2'd0;
   localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
   localparam logic [1:0] MODE_NOTE_ON  = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_STEP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN           = 3'd6;

   // Stage lengths are fixed at 20 bits
   localparam int LEN_W = 20;

   // Commands from the control sequencer to the envelope state
   typedef struct packed {
      logic note_on;   // back to attack, level zero
      logic note_off;  // enter release
      logic advance;   // one sample: step level and counter
   } env_cmd_type;

endpackage

FILE: src/aeg_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module aeg_serial_mul #(
   parameter int A_W      = 18,
   parameter int B_W      = 18,
   parameter bit SIGNED_A = 1'b0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] mcand,
   input  logic [B_W-1:0] mplier,
   output logic           done,
   output logic [A_W:0]   prod_hi,
   output logic [B_W-1:0] prod_lo
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W:0]   acc_ff, acc_in;
   logic [B_W-1:0] mr_ff, mr_in;
   logic [A_W-1:0] a_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   logic [A_W:0]   addend;
   logic [A_W:0]   sum;
   logic           fill;

   // Partial product: multiplicand extended by one bit when bit 0 is set
   assign addend = mr_ff[0] ? {(SIGNED_A ? a_ff[A_W-1] : 1'b0), a_ff} : '0;
   assign sum    = acc_ff + addend;
   assign fill   = SIGNED_A ? sum[A_W] : 1'b0;

   always_comb begin
      acc_in  = acc_ff;
      mr_in   = mr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mr_in   = mplier;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add, then shift the pair right; low product bits enter mr
         acc_in = {fill, sum[A_W:1]};
         mr_in  = {sum[0], mr_ff[B_W-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mr_ff  <= mr_in;
      if (start) begin
         a_ff <= mcand;
      end
   end

   assign done    = done_ff;
   assign prod_hi = acc_ff;
   assign prod_lo = mr_ff;

endmodule

FILE: src/aeg_env.sv
// Envelope state (stage, level, counter, done) and configuration registers.
module aeg_env #(
   parameter int F     = 16,
   parameter int CNT_W = 21,
   parameter int CSR_W = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  aeg_pkg::env_cmd_type         cmd,
   input  logic                         csr_wr_en,
   input  logic [aeg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]             csr_wdata,
   output logic [F+1:0]                 level,
   output logic [F+1:0]                 gain,
   output logic [1:0]                   phase,
   output logic                         finished
);
   import aeg_pkg::*;

   localparam int LVL_W  = F + 2;
   localparam int STEP_W = F + 1;
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   logic [LEN_W-1:0]  attack_len_ff, decay_len_ff, release_len_ff;
   logic [STEP_W-1:0] attack_step_ff, decay_step_ff, release_step_ff;
   logic [LVL_W-1:0]  gain_ff;

   phase_type         phase_ff, phase_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [CNT_W-1:0]  cnt_inc;
   logic [LVL_W:0]    up_sum;
   logic [LVL_W-1:0]  level_up;
   logic [LVL_W-1:0]  dec_step, rel_step;
   logic [LVL_W-1:0]  level_dec, level_rel;
   logic              match_a, match_d, match_r;

   // Saturating counter and level arithmetic
   assign cnt_inc   = (cnt_ff == '1) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign up_sum    = {1'b0, level_ff} + (LVL_W+1)'(attack_step_ff);
   assign level_up  = up_sum[LVL_W] ? '1 : up_sum[LVL_W-1:0];
   assign dec_step  = LVL_W'(decay_step_ff);
   assign rel_step  = LVL_W'(release_step_ff);
   assign level_dec = (level_ff > dec_step) ? level_ff - dec_step : '0;
   assign level_rel = (level_ff > rel_step) ? level_ff - rel_step : '0;

   // Stage-end compares at a common width
   assign match_a = CMP_W'(cnt_ff) == CMP_W'(attack_len_ff);
   assign match_d = CMP_W'(cnt_ff) == CMP_W'(decay_len_ff);
   assign match_r = CMP_W'(cnt_ff) == CMP_W'(release_len_ff);

   // Next envelope state
   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;
      if (cmd.note_on) begin
         phase_in = PH_ATTACK;
         level_in = '0;
         cnt_in   = '0;
         done_in  = 1'b0;
      end else if (cmd.note_off) begin
         phase_in = PH_RELEASE;
         cnt_in   = '0;
      end else if (cmd.advance) begin
         cnt_in = cnt_inc;
         unique case (phase_ff)
            PH_ATTACK: begin
               level_in = level_up;
               if (match_a) begin
                  phase_in = PH_DECAY;
                  cnt_in   = CNT_W'(1);
               end
            end
            PH_DECAY: begin
               level_in = level_dec;
               if (match_d) begin
                  phase_in = PH_SUSTAIN;
                  cnt_in   = CNT_W'(1);
               end
            end
            PH_SUSTAIN: begin
               level_in = level_ff;
            end
            PH_RELEASE: begin
               level_in = level_rel;
               if (match_r) begin
                  done_in = 1'b1;
               end
            end
            default: begin
               level_in = level_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff   <= '0;
         decay_len_ff    <= '0;
         release_len_ff  <= '0;
         attack_step_ff  <= '0;
         decay_step_ff   <= '0;
         release_step_ff <= '0;
         gain_ff         <= LVL_W'(1) << F;
         phase_ff        <= PH_ATTACK;
         level_ff        <= '0;
         cnt_ff          <= '0;
         done_ff         <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
         // register writes; unknown indexes are dropped
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ATTACK_LENGTH:  attack_len_ff   <= csr_wdata[LEN_W-1:0];
               CSR_DECAY_LENGTH:   decay_len_ff    <= csr_wdata[LEN_W-1:0];
               CSR_RELEASE_LENGTH: release_len_ff  <= csr_wdata[LEN_W-1:0];
               CSR_ATTACK_STEP:    attack_step_ff  <= csr_wdata[STEP_W-1:0];
               CSR_DECAY_STEP:     decay_step_ff   <= csr_wdata[STEP_W-1:0];
               CSR_RELEASE_STEP:   release_step_ff <= csr_wdata[STEP_W-1:0];
               CSR_GAIN:           gain_ff         <= csr_wdata[LVL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign level    = level_ff;
   assign gain     = gain_ff;
   assign phase    = phase_ff;
   assign finished = done_ff;

endmodule

FILE: src/adsr_envelope_gain_top.sv
// Top level of the ADSR envelope gain block: sequencer, multipliers, result register.
//
// A sample item (mode 0) runs through two bit-serial multipliers in turn: gain times
// level first, then the sample times the clamped factor, and the next item is taken
// once the result is in the output register. Start, release and unused-mode items give
// no result and are taken without leaving the idle state. The envelope steps at
// acceptance; the result uses the level from before that step and reports stage and
// done after it. Write configuration only when no sample is in flight.
module adsr_envelope_gain_top #(
   parameter int SAMPLE_BITS     = 16,
   parameter int LEVEL_FRAC_BITS = 16,
   parameter int COUNTER_BITS    = 21
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_finished,
   output logic [1:0]                    rsp_phase,
   input  logic                          csr_wr_en,
   input  logic [aeg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [((LEVEL_FRAC_BITS+2 > aeg_pkg::LEN_W) ?
                  LEVEL_FRAC_BITS+2 : aeg_pkg::LEN_W)-1:0] csr_wdata
);
   import aeg_pkg::*;

   localparam int F     = LEVEL_FRAC_BITS;
   localparam int SB    = SAMPLE_BITS;
   localparam int LVL_W = F + 2;
   localparam int G_W   = F + 1;
   localparam int PS_W  = F + 5;
   localparam int CSR_W = (LVL_W > LEN_W) ? LVL_W : LEN_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GAIN_MUL,
      S_SCALE_MUL,
      S_HOLD
   } state_type;

   state_type          state_ff;
   logic [SB-1:0]      sample_ff;
   logic               rsp_valid_ff;
   logic [SB-1:0]      rsp_sample_out_ff;
   logic               rsp_finished_ff;
   logic [1:0]         rsp_phase_ff;

   logic               accept;
   env_cmd_type        cmd;
   logic [LVL_W-1:0]   env_level, env_gain;
   logic [1:0]         env_phase;
   logic               env_finished;

   logic               gmul_start, gmul_done;
   logic [LVL_W:0]     gmul_hi;
   logic [LVL_W-1:0]   gmul_lo;
   logic               smul_start, smul_done;
   logic [SB:0]        smul_hi;
   logic [G_W-1:0]     smul_lo;

   logic [PS_W-1:0]    prod_shift;
   logic [PS_W-1:0]    unity;
   logic [G_W-1:0]     factor;
   logic [SB-1:0]      scaled;
   logic               out_free;
   logic               load_rsp;

   // Handshake and command decode
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = (state_ff == S_HOLD) && out_free;

   always_comb begin
      cmd          = '0;
      cmd.note_on  = accept && (req_mode == MODE_NOTE_ON);
      cmd.note_off = accept && (req_mode == MODE_NOTE_OFF);
      cmd.advance  = accept && (req_mode == MODE_SAMPLE);
   end

   aeg_env #(
      .F     (F),
      .CNT_W (COUNTER_BITS),
      .CSR_W (CSR_W)
   ) u_env (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .level     (env_level),
      .gain      (env_gain),
      .phase     (env_phase),
      .finished  (env_finished)
   );

   // gain * level, started with the level from before this sample's step
   assign gmul_start = cmd.advance;

   aeg_serial_mul #(
      .A_W      (LVL_W),
      .B_W      (LVL_W),
      .SIGNED_A (1'b0)
   ) u_gain_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (gmul_start),
      .mcand   (env_gain),
      .mplier  (env_level),
      .done    (gmul_done),
      .prod_hi (gmul_hi),
      .prod_lo (gmul_lo)
   );

   // factor = min(1, product >> F)
   assign prod_shift = {gmul_hi, gmul_lo[LVL_W-1:F]};
   assign unity      = PS_W'(1) << F;
   assign factor     = (prod_shift > unity) ? unity[G_W-1:0] : prod_shift[G_W-1:0];

   // sample * factor, signed multiplicand
   assign smul_start = (state_ff == S_GAIN_MUL) && gmul_done;

   aeg_serial_mul #(
      .A_W      (SB),
      .B_W      (G_W),
      .SIGNED_A (1'b1)
   ) u_scale_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (smul_start),
      .mcand   (sample_ff),
      .mplier  (factor),
      .done    (smul_done),
      .prod_hi (smul_hi),
      .prod_lo (smul_lo)
   );

   // floor(product / 2^F), low sample bits
   assign scaled = {smul_hi[SB-2:0], smul_lo[F]};

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished item, or clear once the item is taken
         if (load_rsp) begin
            rsp_valid_ff      <= 1'b1;
            rsp_sample_out_ff <= scaled;
            rsp_finished_ff   <= env_finished;
            rsp_phase_ff      <= env_phase;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.advance) begin
                  state_ff <= S_GAIN_MUL;
               end
            end
            S_GAIN_MUL: begin
               if (gmul_done) begin
                  state_ff <= S_SCALE_MUL;
               end
            end
            S_SCALE_MUL: begin
               if (smul_done) begin
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Sample operand held for the second multiply
   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         sample_ff <= req_sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_finished   = rsp_finished_ff;
   assign rsp_phase      = rsp_phase_ff;

endmodule
